@@ hw/rtl/tdlp_pkg.sv @@
// Shared types and constants for the temporal denoise lowpass block.
package tdlp_pkg;

    // Operation codes carried on the op field
    typedef enum logic [1:0] {
        OP_FILTER = 2'd0,
        OP_SEED   = 2'd1,
        OP_TABLE  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Upper bound of the accumulator and the rounding bias
    localparam logic [15:0] ACC_MAX  = 16'hFF00;
    localparam logic [7:0]  ROUND_OFS = 8'h7F;

    // Output queue that decouples the pipeline from a stalling receiver
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_AW + 1;

    // Per-item control that rides along the pipeline
    typedef struct packed {
        logic       seed;
        logic       chroma;
        logic [7:0] sample;
    } item_t;

endpackage

@@ hw/rtl/tdlp_out_fifo.sv @@
// Small output queue holding result words until the receiver takes them.
module tdlp_out_fifo (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  logic [7:0]                       push_data,
    output logic [tdlp_pkg::FIFO_CNT_W-1:0]  count,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [7:0]                       out_data
);
    import tdlp_pkg::*;

    logic [7:0]            mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    wr_ptr_reg;
    logic [FIFO_AW-1:0]    wr_ptr_next;
    logic [FIFO_AW-1:0]    rd_ptr_reg;
    logic [FIFO_AW-1:0]    rd_ptr_next;
    logic [FIFO_CNT_W-1:0] cnt_reg;
    logic [FIFO_CNT_W-1:0] cnt_next;
    logic                  pop;

    // Drain the head word when the receiver takes it
    assign pop       = out_valid && !out_stall;
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign count     = cnt_reg;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/temporal_denoise_lut_lowpass.sv @@
// Top level of the per-byte recursive temporal lowpass with lookup-table correction.
//
// Input channel (in_valid / in_stall) carries one word per cycle unless
// stalled: a filter word, a seed word, or a table write word selected by op.
// Output channel (out_valid / out_stall) carries filtered_sample for each
// filter or seed word whose byte_index lies inside the frame; table writes,
// the unused op and out-of-frame words give no output word.
// Path: an accepted word passes the stage 1 and stage 2 registers and is
// then written into the output queue. Throughput: one word per cycle
// unless stalled. The accumulator memory is read at accept and written
// back from stage 2; a same-entry read in between is served by
// forwarding, so back-to-back words at one index never wait.
// A four-word output queue sits in front of out_*. When the receiver stalls,
// the pipeline keeps running into the queue and in_stall rises only once the
// queue plus words still in flight reach four.
// Reset clears the pipeline and the queue. Accumulator and table contents are
// not cleared: load every table entry and seed every byte position before a
// filter word touches it.
module temporal_denoise_lut_lowpass #(
    parameter int FRAME_BYTES       = 4194304,
    parameter int BUCKET_SHIFT_BITS = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic [21:0]        byte_index,
    input  logic [7:0]         sample,
    input  logic               use_chroma,
    input  logic [12:0]        table_addr,
    input  logic signed [15:0] table_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         filtered_sample
);
    import tdlp_pkg::*;

    localparam int ACC_AW     = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int DIFF_SHIFT = 8 - BUCKET_SHIFT_BITS;
    localparam int TBL_CENTER = 256 << BUCKET_SHIFT_BITS;
    localparam int TBL_SIZE   = 512 << BUCKET_SHIFT_BITS;
    localparam int TBL_AW     = 9 + BUCKET_SHIFT_BITS;

    // Storage
    logic [15:0]        acc_mem   [FRAME_BYTES];
    logic signed [15:0] luma_mem  [TBL_SIZE];
    logic signed [15:0] chroma_mem[TBL_SIZE];

    // Accept and decode
    logic              in_acc;
    logic              idx_ok;
    logic              do_pix;
    logic              do_tbl;
    logic [31:0]       idx_ext;
    logic [31:0]       taddr_ext;
    logic [ACC_AW-1:0] acc_ra;
    logic [TBL_AW-1:0] tbl_wa;
    item_t             in_item;

    // Stage 1: accumulator data back, bucket and table address
    logic              s1_valid_reg;
    item_t             s1_item_reg;
    logic [ACC_AW-1:0] s1_addr_reg;
    logic [15:0]       acc_rd_reg;
    logic [15:0]       acc_fwd;
    logic signed [16:0] diff;
    logic signed [16:0] bucket;
    logic signed [18:0] pos;
    logic [TBL_AW-1:0] tbl_ra;

    // Stage 2: table data back, correct, clamp, write back
    logic               s2_valid_reg;
    item_t              s2_item_reg;
    logic [ACC_AW-1:0]  s2_addr_reg;
    logic signed [15:0] luma_rd_reg;
    logic signed [15:0] chroma_rd_reg;
    logic signed [15:0] corr;
    logic signed [17:0] sum;
    logic [15:0]        v_clamp;
    logic [16:0]        v_round;
    logic [15:0]        s2_wd;
    logic [7:0]         s2_byte;

    // Last write, for a read that met it at the same edge
    logic              wl_valid_reg;
    logic [ACC_AW-1:0] wl_addr_reg;
    logic [15:0]       wl_data_reg;

    // Output queue credit
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [FIFO_CNT_W+1:0] in_flight;

    // Hold input while queue plus in-flight words fill the queue
    assign in_flight = (FIFO_CNT_W + 2)'(fifo_count) + (FIFO_CNT_W + 2)'(s1_valid_reg)
                     + (FIFO_CNT_W + 2)'(s2_valid_reg);
    assign in_stall  = (in_flight >= (FIFO_CNT_W + 2)'(FIFO_DEPTH));
    assign in_acc    = in_valid && !in_stall;

    // Decode the word
    always_comb
    begin
        idx_ext   = 32'(byte_index);
        taddr_ext = 32'(table_addr);
        idx_ok    = (idx_ext < 32'(FRAME_BYTES));
        do_pix    = in_acc && idx_ok && ((op == OP_FILTER) || (op == OP_SEED));
        do_tbl    = in_acc && (op == OP_TABLE) && (taddr_ext < 32'(TBL_SIZE));
        acc_ra    = idx_ext[ACC_AW-1:0];
        tbl_wa    = taddr_ext[TBL_AW-1:0];
        in_item.seed   = (op == OP_SEED);
        in_item.chroma = use_chroma;
        in_item.sample = sample;
    end

    // Accumulator memory: read at accept, write back from stage 2
    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            acc_mem[s2_addr_reg] <= s2_wd;
        end
        acc_rd_reg <= acc_mem[acc_ra];
    end

    // Tables: write at accept, read from stage 1
    always_ff @(posedge clk)
    begin
        if (do_tbl && !use_chroma)
        begin
            luma_mem[tbl_wa] <= table_value;
        end
        luma_rd_reg <= luma_mem[tbl_ra];
    end

    always_ff @(posedge clk)
    begin
        if (do_tbl && use_chroma)
        begin
            chroma_mem[tbl_wa] <= table_value;
        end
        chroma_rd_reg <= chroma_mem[tbl_ra];
    end

    // Forward the newest value of the entry, then bucket the difference
    always_comb
    begin
        priority if (s2_valid_reg && (s2_addr_reg == s1_addr_reg))
        begin
            acc_fwd = s2_wd;
        end
        else if (wl_valid_reg && (wl_addr_reg == s1_addr_reg))
        begin
            acc_fwd = wl_data_reg;
        end
        else
        begin
            acc_fwd = acc_rd_reg;
        end

        diff   = $signed({1'b0, acc_fwd}) - $signed({1'b0, s1_item_reg.sample, 8'h00});
        bucket = diff >>> DIFF_SHIFT;
        pos    = 19'(bucket) + 19'(TBL_CENTER);

        priority if (pos < 19'sd0)
        begin
            tbl_ra = '0;
        end
        else if (pos > 19'(TBL_SIZE - 1))
        begin
            tbl_ra = TBL_AW'(TBL_SIZE - 1);
        end
        else
        begin
            tbl_ra = pos[TBL_AW-1:0];
        end
    end

    // Add the correction, clamp, and round to a byte; a seed word passes its sample through
    always_comb
    begin
        corr = s2_item_reg.chroma ? chroma_rd_reg : luma_rd_reg;
        sum  = $signed({2'b00, s2_item_reg.sample, 8'h00}) + 18'(corr);

        priority if (sum < 18'sd0)
        begin
            v_clamp = '0;
        end
        else if (sum > $signed({2'b00, ACC_MAX}))
        begin
            v_clamp = ACC_MAX;
        end
        else
        begin
            v_clamp = sum[15:0];
        end

        v_round = {1'b0, v_clamp} + 17'(ROUND_OFS);

        if (s2_item_reg.seed)
        begin
            s2_wd   = {s2_item_reg.sample, 8'h00};
            s2_byte = s2_item_reg.sample;
        end
        else
        begin
            s2_wd   = v_clamp;
            s2_byte = v_round[15:8];
        end
    end

    // Advance pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            wl_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= do_pix;
            s2_valid_reg <= s1_valid_reg;
            wl_valid_reg <= s2_valid_reg;
        end
    end

    // Advance pipeline payload
    always_ff @(posedge clk)
    begin
        s1_item_reg <= in_item;
        s1_addr_reg <= acc_ra;
        s2_item_reg <= s1_item_reg;
        s2_addr_reg <= s1_addr_reg;
        wl_addr_reg <= s2_addr_reg;
        wl_data_reg <= s2_wd;
    end

    tdlp_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s2_valid_reg),
        .push_data (s2_byte),
        .count     (fifo_count),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (filtered_sample)
    );

endmodule
